@@ sv/imuoc_pkg.sv @@
// Shared types, constants and helper functions of the IMU offset calibration filter.
package imuoc_pkg;

   localparam int WINDOW_LEN_DEF  = 8;
   localparam int CAL_SAMPLES_DEF = 512;

   localparam int SAMPLE_W    = 16;
   localparam int AXES        = 6;
   localparam int GROUP_AXES  = 3;
   localparam int GROUPS      = 2;
   localparam int OUT_W       = 19;
   localparam int ONE_G       = 4096;
   localparam int GYRO_GAIN   = 1000;
   localparam int GYRO_GAIN_W = 11;
   localparam int GYRO_SHIFT  = 7;
   localparam int GYRO_LIMIT  = 256000;

   localparam int IN_DATA_W  = ((AXES * SAMPLE_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((AXES * OUT_W + 7) / 8) * 8;

   localparam int GRP_ACC  = 0;
   localparam int GRP_GYRO = 1;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type [GROUP_AXES-1:0] triple_type;
   typedef sample_type [AXES-1:0] axes_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cal_stat_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } div_en_type;

   function automatic sample_type sat16(input logic signed [31:0] v);
      sample_type r;
      if (v > 32'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ sv/imu_offset_cal_moving_average.sv @@
// Top level of the IMU offset calibration and moving-average filter.
// Stages in order: raw, divide A/B, correct, sum, gyro product, gyro divide A/B, out.
// Throughput: one sample per clock cycle while results are taken; each pipeline stage
// moves on when the next has room, so a stall does not hold back stages with gaps.
// Reset is synchronous and clears calibration state, offsets, window taps and sums
// and all stage valids; there is no clearing pass.
module imu_offset_cal_moving_average #(
   parameter int WINDOW_LEN  = imuoc_pkg::WINDOW_LEN_DEF,
   parameter int CAL_SAMPLES = imuoc_pkg::CAL_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // raw_acc_x, raw_acc_y, raw_acc_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
   input  logic [imuoc_pkg::IN_DATA_W-1:0]  req_tdata,
   // start_acc_cal, start_gyro_cal
   input  logic [imuoc_pkg::GROUPS-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // acc_x_sum, acc_y_sum, acc_z_sum, gyro_x_rate, gyro_y_rate, gyro_z_rate, zero fill
   output logic [imuoc_pkg::OUT_DATA_W-1:0] rsp_tdata,
   // acc_cal_busy, gyro_cal_busy
   output logic [imuoc_pkg::GROUPS-1:0]     rsp_tuser
);
   import imuoc_pkg::*;

   localparam int ST_RAW   = 0;
   localparam int ST_DIVA  = 1;
   localparam int ST_DIVB  = 2;
   localparam int ST_CORR  = 3;
   localparam int ST_SUM   = 4;
   localparam int ST_GPROD = 5;
   localparam int ST_GDIVA = 6;
   localparam int ST_GDIVB = 7;
   localparam int ST_OUT   = 8;
   localparam int NSTAGE   = ST_OUT + 1;

   localparam int ACC_W  = SAMPLE_W + 1 + $clog2(CAL_SAMPLES);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int PROD_W = SUM_W + GYRO_GAIN_W;
   localparam int GDIV_W = PROD_W - GYRO_SHIFT;

   logic [NSTAGE-1:0] v_ff, v_in;
   logic [NSTAGE-1:0] can_load;
   logic              enter_raw, enter_corr, enter_sum;

   axes_type                          in_axes;
   cal_stat_type [GROUPS-1:0]         cal_stat;
   logic [AXES-1:0][ACC_W-1:0]        cal_sum;
   logic [AXES-1:0][ACC_W-1:0]        cal_sum_ff;
   logic [AXES-1:0][ACC_W-1:0]        cal_q;
   div_en_type                        cal_en, gyro_en;

   axes_type                          raw_ff [ST_DIVB+1];
   logic [GROUPS-1:0]                 busy_ff [NSTAGE];
   logic [GROUPS-1:0]                 done_ff [ST_DIVB+1];

   axes_type                          off_use;
   axes_type                          corr_in, corr_ff;
   axes_type                          offset_ff, offset_in;
   axes_type                          taps [WINDOW_LEN];

   logic [AXES-1:0][SUM_W-1:0]        sum_ff, sum_in;
   logic [GROUP_AXES-1:0][SUM_W-1:0]  accsum_ff [ST_GPROD:ST_GDIVB];
   logic [GROUP_AXES-1:0][PROD_W-1:0] gprod_ff, gprod_in;
   logic [GROUP_AXES-1:0][GDIV_W-1:0] gdiv_x, gdiv_q;
   logic [AXES-1:0][OUT_W-1:0]        out_ff, out_in;

   // Stage handshake: a stage loads when it is empty or its content moves on.
   always_comb begin
      can_load[ST_OUT] = ~v_ff[ST_OUT] | rsp_tready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         can_load[k] = ~v_ff[k] | can_load[k+1];
      end
      v_in[ST_RAW] = can_load[ST_RAW] ? req_tvalid : v_ff[ST_RAW];
      for (int k = 1; k < NSTAGE; k++) begin
         v_in[k] = can_load[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   assign enter_raw  = can_load[ST_RAW] & req_tvalid;
   assign enter_corr = can_load[ST_CORR] & v_ff[ST_DIVB];
   assign enter_sum  = can_load[ST_SUM] & v_ff[ST_CORR];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = can_load[ST_RAW];
   assign rsp_tvalid = v_ff[ST_OUT];
   assign in_axes    = req_tdata[AXES*SAMPLE_W-1:0];

   imuoc_cal #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .SUB_ONE_G   (1'b1),
      .ACC_W       (ACC_W)
   ) u_cal_acc (
      .clock   (clock),
      .reset   (reset),
      .accept  (enter_raw),
      .start   (req_tuser[GRP_ACC]),
      .sample  (in_axes[GROUP_AXES-1:0]),
      .stat    (cal_stat[GRP_ACC]),
      .sum_out (cal_sum[GROUP_AXES-1:0])
   );

   imuoc_cal #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .SUB_ONE_G   (1'b0),
      .ACC_W       (ACC_W)
   ) u_cal_gyro (
      .clock   (clock),
      .reset   (reset),
      .accept  (enter_raw),
      .start   (req_tuser[GRP_GYRO]),
      .sample  (in_axes[AXES-1:GROUP_AXES]),
      .stat    (cal_stat[GRP_GYRO]),
      .sum_out (cal_sum[AXES-1:GROUP_AXES])
   );

   assign cal_en.load_a  = can_load[ST_DIVA];
   assign cal_en.load_b  = can_load[ST_DIVB];
   assign gyro_en.load_a = can_load[ST_GDIVA];
   assign gyro_en.load_b = can_load[ST_GDIVB];

   for (genvar i = 0; i < AXES; i++) begin : g_cal_div
      imuoc_divc #(
         .IN_W    (ACC_W),
         .DIVISOR (CAL_SAMPLES)
      ) u_div (
         .clock (clock),
         .en    (cal_en),
         .x     (cal_sum_ff[i]),
         .q     (cal_q[i])
      );
   end

   // Offsets of a calibration that ends with this sample already apply to it.
   always_comb begin
      offset_in = offset_ff;
      for (int i = 0; i < AXES; i++) begin
         off_use[i] = done_ff[ST_DIVB][(i < GROUP_AXES) ? GRP_ACC : GRP_GYRO]
                    ? sat16(32'($signed(cal_q[i]))) : offset_ff[i];
         corr_in[i] = sat16(32'($signed(raw_ff[ST_DIVB][i])) - 32'($signed(off_use[i])));
      end
      if (enter_corr) begin
         offset_in = off_use;
      end
   end

   for (genvar c = 0; c < WINDOW_LEN; c++) begin : g_cell
      if (c == 0) begin : g_head
         imuoc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (enter_sum),
            .din   (corr_ff),
            .dout  (taps[c])
         );
      end else begin : g_tail
         imuoc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (enter_sum),
            .din   (taps[c-1]),
            .dout  (taps[c])
         );
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (enter_sum) begin
         for (int i = 0; i < AXES; i++) begin
            sum_in[i] = $signed(sum_ff[i]) + SUM_W'($signed(corr_ff[i]))
                      - SUM_W'($signed(taps[WINDOW_LEN-1][i]));
         end
      end
      for (int j = 0; j < GROUP_AXES; j++) begin
         gprod_in[j] = PROD_W'($signed(sum_ff[GROUP_AXES+j])) * PROD_W'(GYRO_GAIN);
         gdiv_x[j]   = GDIV_W'($signed(gprod_ff[j]) >>> GYRO_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sum_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

   for (genvar j = 0; j < GROUP_AXES; j++) begin : g_gyro_div
      imuoc_divc #(
         .IN_W    (GDIV_W),
         .DIVISOR (WINDOW_LEN)
      ) u_div (
         .clock (clock),
         .en    (gyro_en),
         .x     (gdiv_x[j]),
         .q     (gdiv_q[j])
      );
   end

   always_comb begin
      for (int i = 0; i < GROUP_AXES; i++) begin
         out_in[i]              = OUT_W'($signed(accsum_ff[ST_GDIVB][i]));
         out_in[GROUP_AXES + i] = OUT_W'($signed(gdiv_q[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (can_load[ST_RAW]) begin
         raw_ff[ST_RAW]  <= in_axes;
         cal_sum_ff      <= cal_sum;
         busy_ff[ST_RAW] <= {cal_stat[GRP_GYRO].busy, cal_stat[GRP_ACC].busy};
         done_ff[ST_RAW] <= {cal_stat[GRP_GYRO].done, cal_stat[GRP_ACC].done};
      end
      for (int k = ST_DIVA; k <= ST_DIVB; k++) begin
         if (can_load[k]) begin
            raw_ff[k]  <= raw_ff[k-1];
            done_ff[k] <= done_ff[k-1];
         end
      end
      for (int k = ST_DIVA; k < NSTAGE; k++) begin
         if (can_load[k]) begin
            busy_ff[k] <= busy_ff[k-1];
         end
      end
      if (can_load[ST_CORR]) begin
         corr_ff <= corr_in;
      end
      if (can_load[ST_GPROD]) begin
         accsum_ff[ST_GPROD] <= sum_ff[GROUP_AXES-1:0];
         gprod_ff            <= gprod_in;
      end
      for (int k = ST_GDIVA; k <= ST_GDIVB; k++) begin
         if (can_load[k]) begin
            accsum_ff[k] <= accsum_ff[k-1];
         end
      end
      if (can_load[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*OUT_W +: OUT_W] = out_ff[i];
      end
   end

   assign rsp_tuser = busy_ff[ST_OUT];

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready although the result register is empty");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_RAW] |-> ((busy_ff[ST_RAW] & done_ff[ST_RAW]) == '0))
      else $error("calibration reported busy on its final sample");

   a_gyro_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(out_ff[GROUP_AXES]) <= GYRO_LIMIT)
         && ($signed(out_ff[GROUP_AXES]) >= -GYRO_LIMIT)
         && ($signed(out_ff[GROUP_AXES+1]) <= GYRO_LIMIT)
         && ($signed(out_ff[GROUP_AXES+1]) >= -GYRO_LIMIT)
         && ($signed(out_ff[GROUP_AXES+2]) <= GYRO_LIMIT)
         && ($signed(out_ff[GROUP_AXES+2]) >= -GYRO_LIMIT))
      else $error("gyro rate outside its possible range");

endmodule

@@ sv/imuoc_cell.sv @@
// One tap of the moving-average window: holds the corrected sample of all six axes.
module imuoc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  imuoc_pkg::axes_type din,
   output imuoc_pkg::axes_type dout
);
   import imuoc_pkg::*;

   axes_type tap_ff;
   axes_type tap_in;

   always_comb begin
      tap_in = shift ? din : tap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign dout = tap_ff;

endmodule

@@ sv/imuoc_cal.sv @@
// Offset calibration collector for one three-axis sensor group.
module imuoc_cal #(
   parameter int CAL_SAMPLES = imuoc_pkg::CAL_SAMPLES_DEF,
   parameter bit SUB_ONE_G   = 1'b0,
   parameter int ACC_W       = imuoc_pkg::SAMPLE_W + 1 + $clog2(CAL_SAMPLES)
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           accept,
   input  logic                                           start,
   input  imuoc_pkg::triple_type                          sample,
   output imuoc_pkg::cal_stat_type                        stat,
   output logic [imuoc_pkg::GROUP_AXES-1:0][ACC_W-1:0]    sum_out
);
   import imuoc_pkg::*;

   localparam int CNT_W = $clog2(CAL_SAMPLES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAL_SAMPLES - 1);

   logic                                active_ff, active_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [GROUP_AXES-1:0][ACC_W-1:0]    acc_ff, acc_in;
   logic [GROUP_AXES-1:0][ACC_W-1:0]    acc_new;
   logic                                run;
   logic                                done;

   always_comb begin
      logic signed [ACC_W-1:0] base;
      logic signed [ACC_W-1:0] ext;
      run  = active_ff | start;
      done = active_ff & (count_ff == LAST_CNT);
      for (int i = 0; i < GROUP_AXES; i++) begin
         base = active_ff ? $signed(acc_ff[i]) : '0;
         ext  = ACC_W'($signed(sample[i]));
         if (SUB_ONE_G && (i == GROUP_AXES - 1)) begin
            ext = ext - ACC_W'(ONE_G);
         end
         acc_new[i] = base + ext;
      end

      active_in = active_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      if (accept) begin
         if (done) begin
            active_in = 1'b0;
            count_in  = '0;
            acc_in    = '0;
         end else if (run) begin
            active_in = 1'b1;
            count_in  = CNT_W'((active_ff ? count_ff : '0) + 1'b1);
            acc_in    = acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         acc_ff    <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
      end
   end

   assign stat.busy = run & ~done;
   assign stat.done = done;
   assign sum_out   = acc_new;

endmodule

@@ sv/imuoc_divc.sv @@
// Two-stage floor division of a signed value by a constant, using a reciprocal multiply.
module imuoc_divc #(
   parameter int IN_W    = 24,
   parameter int DIVISOR = 8
) (
   input  logic                  clock,
   input  imuoc_pkg::div_en_type en,
   input  logic [IN_W-1:0]       x,
   output logic [IN_W-1:0]       q
);
   import imuoc_pkg::*;

   localparam int N  = IN_W - 1;
   localparam int L  = $clog2(DIVISOR);
   localparam int S  = N + L;
   localparam int MW = N + 2;
   localparam int PW = N + MW;
   localparam logic [63:0] MAGIC_FULL = ((64'd1 << S) / 64'(DIVISOR)) + 64'd1;
   localparam logic [MW-1:0] MAGIC = MAGIC_FULL[MW-1:0];

   logic          neg_a_ff, neg_b_ff;
   logic [N-1:0]  mag_a_ff, mag_in;
   logic [PW-1:0] prod_b_ff, prod_in;
   logic [PW-1:0] prod_shift;

   always_comb begin
      mag_in  = x[N] ? ~x[N-1:0] : x[N-1:0];
      prod_in = PW'(mag_a_ff) * PW'(MAGIC);
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         neg_a_ff <= x[N];
         mag_a_ff <= mag_in;
      end
      if (en.load_b) begin
         neg_b_ff  <= neg_a_ff;
         prod_b_ff <= prod_in;
      end
   end

   assign prod_shift = prod_b_ff >> S;
   assign q = neg_b_ff ? ~{1'b0, prod_shift[N-1:0]} : {1'b0, prod_shift[N-1:0]};

endmodule
